// File: rtl/binomial_tree_option_pricer_assert.svh
// ----------------------------------------------------------------------------
// Binomial tree pricer assertion macros
// Concurrent checks on clk with synchronous active-low reset; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef BINOMIAL_TREE_OPTION_PRICER_ASSERT_SVH
`define BINOMIAL_TREE_OPTION_PRICER_ASSERT_SVH

`ifndef SYNTHESIS
`define BTO_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define BTO_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BTO_ASSERT(label, cond)
`define BTO_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/bto_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binomial tree pricer package
// Shared constants, register indexes, issue control and the payoff function.
// ----------------------------------------------------------------------------
package bto_pkg;

  localparam int MAX_STEPS_DEF = 256;

  localparam logic [31:0] Q_ONE  = 32'h4000_0000;
  localparam logic [31:0] Q_HALF = 32'h2000_0000;
  localparam logic [31:0] P_MAX  = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    CFG_UP_FACTOR    = 3'd0,
    CFG_DOWN_FACTOR  = 3'd1,
    CFG_PROB_UP      = 3'd2,
    CFG_STEP_DISC    = 3'd3,
    CFG_NUM_STEPS    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic vld;       // node operation enters the pipeline
    logic seed;      // write the root spot at level zero
    logic fwd;       // forward spot fill, else backward roll
    logic use_down;  // forward: lowest node takes the down factor
    logic leaf;      // forward: last level, write leaf payoff
    logic root;      // result lands in the root value
  } issue_ctl_t;

  function automatic logic [31:0] payoff_f(logic [31:0] s, logic [31:0] k, logic put);
    logic [31:0] r;
    if (put) r = (k > s) ? (k - s) : 32'd0;
    else     r = (s > k) ? (s - k) : 32'd0;
    return r;
  endfunction

endpackage

// File: rtl/bto_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binomial tree sequencer
// Walks the tree forward level by level, then backward to the root.
// ----------------------------------------------------------------------------
module bto_seq
  import bto_pkg::*;
#(
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  input  logic [$clog2(MAX_STEPS+1)-1:0]          n_in,
  input  logic                                    busy,
  input  logic                                    out_free,
  output logic                                    idle,
  output logic                                    done,
  output issue_ctl_t                              ctl,
  output logic [$clog2((MAX_STEPS+1)*(MAX_STEPS+2)/2)-1:0] spot_rd,
  output logic [$clog2((MAX_STEPS+1)*(MAX_STEPS+2)/2)-1:0] spot_wr,
  output logic [$clog2(MAX_STEPS+1)-1:0]          vaddr
);

  localparam int VA_W = $clog2(MAX_STEPS + 1);
  localparam int SA_W = $clog2((MAX_STEPS + 1) * (MAX_STEPS + 2) / 2);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_INIT   = 7'b0000010,
    S_FWD    = 7'b0000100,
    S_FDRAIN = 7'b0001000,
    S_BWD    = 7'b0010000,
    S_BDRAIN = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [VA_W-1:0]   level_r, level_nxt;
  logic [VA_W-1:0]   j_r, j_nxt;
  logic [VA_W-1:0]   n_r, n_nxt;
  logic [SA_W-1:0]   bp_r, bp_nxt;   // base of previous level (forward) or current level
  logic [SA_W-1:0]   bc_r, bc_nxt;   // base of level being filled

  always_comb begin
    state_nxt = state_r;
    level_nxt = level_r;
    j_nxt     = j_r;
    n_nxt     = n_r;
    bp_nxt    = bp_r;
    bc_nxt    = bc_r;
    ctl       = '0;
    done      = 1'b0;
    spot_rd   = bp_r + SA_W'(j_r);
    spot_wr   = bc_r + SA_W'(j_r);
    vaddr     = j_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          n_nxt     = n_in;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        ctl.seed = 1'b1;
        ctl.root = (n_r == '0);
        if (n_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          level_nxt = VA_W'(1);
          j_nxt     = '0;
          bp_nxt    = '0;
          bc_nxt    = SA_W'(1);
          state_nxt = S_FWD;
        end
      end
      S_FWD: begin
        ctl.vld      = 1'b1;
        ctl.fwd      = 1'b1;
        ctl.use_down = (j_r == level_r);
        ctl.leaf     = (level_r == n_r);
        if (j_r == level_r) spot_rd = bp_r + SA_W'(j_r) - SA_W'(1);
        j_nxt = VA_W'(j_r + 1'b1);
        if (j_r == level_r) state_nxt = S_FDRAIN;
      end
      S_FDRAIN: begin
        if (!busy) begin
          j_nxt = '0;
          if (level_r == n_r) begin
            level_nxt = VA_W'(n_r - 1'b1);
            state_nxt = S_BWD;
          end else begin
            level_nxt = VA_W'(level_r + 1'b1);
            bp_nxt    = bc_r;
            bc_nxt    = bc_r + SA_W'(level_r) + SA_W'(1);
            state_nxt = S_FWD;
          end
        end
      end
      S_BWD: begin
        ctl.vld  = 1'b1;
        ctl.root = (level_r == '0);
        j_nxt    = VA_W'(j_r + 1'b1);
        if (j_r == level_r) state_nxt = S_BDRAIN;
      end
      S_BDRAIN: begin
        if (!busy) begin
          if (level_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            level_nxt = VA_W'(level_r - 1'b1);
            bp_nxt    = bp_r - SA_W'(level_r);
            j_nxt     = '0;
            state_nxt = S_BWD;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign idle = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      level_r <= '0;
      j_r     <= '0;
      n_r     <= '0;
      bp_r    <= '0;
      bc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      level_r <= level_nxt;
      j_r     <= j_nxt;
      n_r     <= n_nxt;
      bp_r    <= bp_nxt;
      bc_r    <= bc_nxt;
    end
  end

endmodule

// File: rtl/bto_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binomial tree node pipeline
// Spot and node stores with a four-stage multiply, round and clip datapath.
// ----------------------------------------------------------------------------
module bto_dp
  import bto_pkg::*;
#(
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  issue_ctl_t                              ctl,
  input  logic [$clog2((MAX_STEPS+1)*(MAX_STEPS+2)/2)-1:0] spot_rd,
  input  logic [$clog2((MAX_STEPS+1)*(MAX_STEPS+2)/2)-1:0] spot_wr,
  input  logic [$clog2(MAX_STEPS+1)-1:0]          vaddr,
  input  logic [31:0]                             seed_spot,
  input  logic [31:0]                             strike,
  input  logic                                    is_put,
  input  logic                                    american,
  input  logic [31:0]                             up_factor,
  input  logic [30:0]                             down_factor,
  input  logic [30:0]                             p_w,
  input  logic [30:0]                             q_w,
  input  logic [31:0]                             step_discount,
  output logic                                    busy,
  output logic [31:0]                             root_val,
  output logic                                    sat
);

  localparam int VA_W   = $clog2(MAX_STEPS + 1);
  localparam int SDEPTH = (MAX_STEPS + 1) * (MAX_STEPS + 2) / 2;
  localparam int SA_W   = $clog2(SDEPTH);
  localparam logic [64:0] RND = {33'd0, Q_HALF};

  logic [32:0] spot_mem [SDEPTH];      // {chain saturated, spot}
  logic [31:0] val_mem  [MAX_STEPS+1];

  issue_ctl_t      c1_r, c2_r, c3_r, c4_r;
  logic [SA_W-1:0] wa1_r, wa2_r, wa3_r, wa4_r;
  logic [VA_W-1:0] va1_r, va2_r, va3_r, va4_r;
  logic [32:0]     srd1_r;
  logic [31:0]     a1_r, b1_r;
  logic [31:0]     spot2_r;
  logic            ssat2_r, ssat3_r, ssat4_r;
  logic [63:0]     pa2_r;
  logic [62:0]     pb2_r;
  logic [31:0]     val3_r, ex3_r, val4_r, ex4_r;
  logic [63:0]     prod4_r;
  logic [31:0]     root_r;
  logic            sat_r;

  // stage 1: registered store reads
  always_ff @(posedge clk) begin
    srd1_r <= spot_mem[spot_rd];
    a1_r   <= val_mem[vaddr];
    b1_r   <= val_mem[VA_W'(vaddr + 1'b1)];
    wa1_r  <= spot_wr;
    va1_r  <= vaddr;
  end

  // stage 2: products
  logic [31:0] factor1;
  assign factor1 = c1_r.use_down ? {1'b0, down_factor} : up_factor;

  always_ff @(posedge clk) begin
    pa2_r   <= c1_r.fwd ? (64'(srd1_r[31:0]) * 64'(factor1)) : (64'(p_w) * 64'(a1_r));
    pb2_r   <= 63'(q_w) * 63'(b1_r);
    spot2_r <= srd1_r[31:0];
    ssat2_r <= srd1_r[32];
    wa2_r   <= wa1_r;
    va2_r   <= va1_r;
  end

  // stage 3: round and clip, or weighted mix
  logic [64:0] fsum2, bsum2;
  logic        fclip2;
  assign fsum2  = {1'b0, pa2_r} + RND;
  assign bsum2  = {1'b0, pa2_r} + {2'b0, pb2_r} + RND;
  assign fclip2 = |fsum2[64:62];

  always_ff @(posedge clk) begin
    if (c2_r.fwd) val3_r <= fclip2 ? P_MAX : fsum2[61:30];
    else          val3_r <= bsum2[61:30];
    ssat3_r <= ssat2_r | (c2_r.fwd & fclip2);
    ex3_r   <= payoff_f(spot2_r, strike, is_put);
    wa3_r   <= wa2_r;
    va3_r   <= va2_r;
  end

  // stage 4: discount product, leaf payoff
  always_ff @(posedge clk) begin
    prod4_r <= 64'(val3_r) * 64'(step_discount);
    ex4_r   <= c3_r.fwd ? payoff_f(val3_r, strike, is_put) : ex3_r;
    val4_r  <= val3_r;
    ssat4_r <= ssat3_r;
    wa4_r   <= wa3_r;
    va4_r   <= va3_r;
  end

  // write back
  logic [64:0] vsum4;
  logic        vclip4;
  logic [31:0] v4, bval4;
  assign vsum4  = {1'b0, prod4_r} + RND;
  assign vclip4 = |vsum4[64:62];
  assign v4     = vclip4 ? P_MAX : vsum4[61:30];
  assign bval4  = (american && (ex4_r > v4)) ? ex4_r : v4;

  logic [31:0] seed_pay;
  assign seed_pay = payoff_f(seed_spot, strike, is_put);

  always_ff @(posedge clk) begin
    if (ctl.seed) begin
      spot_mem[SA_W'(0)] <= {1'b0, seed_spot};
    end else if (c4_r.vld && c4_r.fwd) begin
      spot_mem[wa4_r] <= {ssat4_r, val4_r};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.seed) begin
      sat_r <= 1'b0;
      if (ctl.root) begin
        val_mem[VA_W'(0)] <= seed_pay;
        root_r            <= seed_pay;
      end
    end else if (c4_r.vld) begin
      if (c4_r.fwd) begin
        if (c4_r.leaf) begin
          val_mem[va4_r] <= ex4_r;
          sat_r          <= sat_r | ssat4_r;
        end
      end else begin
        val_mem[va4_r] <= bval4;
        sat_r          <= sat_r | vclip4 | (american & ssat4_r);
        if (c4_r.root) root_r <= bval4;
      end
    end
  end

  // control travels alongside the data; seeds never enter the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
      c4_r <= '0;
    end else begin
      c1_r <= ctl.vld ? ctl : '0;
      c2_r <= c1_r;
      c3_r <= c2_r;
      c4_r <= c3_r;
    end
  end

  assign busy     = c1_r.vld | c2_r.vld | c3_r.vld | c4_r.vld;
  assign root_val = root_r;
  assign sat      = sat_r;

endmodule

// File: rtl/binomial_tree_option_pricer.sv
`timescale 1ns / 1ps
// The forward spot fill and backward roll each issue one node per cycle within a
// level into a four-stage pipeline and drain it between levels.
// Throughput: one request at a time; the next is taken while a result waits.
// Reset: synchronous, active low; clears control and loads the register defaults.
// ----------------------------------------------------------------------------
// Binomial tree option pricer
// Cox-Ross-Rubinstein tree in fixed point with European or American exercise.
// ----------------------------------------------------------------------------
`include "binomial_tree_option_pricer_assert.svh"

module binomial_tree_option_pricer
  import bto_pkg::*;
#(
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_spot,
  input  logic [31:0] in_strike,
  input  logic        in_is_put,
  input  logic        in_american,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_price,
  output logic        out_saturated,
  // configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  localparam int VA_W = $clog2(MAX_STEPS + 1);
  localparam int SA_W = $clog2((MAX_STEPS + 1) * (MAX_STEPS + 2) / 2);

  // tree factors, held between requests
  logic [31:0] up_r;
  logic [30:0] down_r;
  logic [30:0] prob_r;
  logic [31:0] disc_r;
  logic [8:0]  steps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_r    <= Q_ONE;
      down_r  <= Q_ONE[30:0];
      prob_r  <= Q_HALF[30:0];
      disc_r  <= Q_ONE;
      steps_r <= 9'd1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_UP_FACTOR:   up_r    <= cfg_wdata;
        CFG_DOWN_FACTOR: down_r  <= cfg_wdata[30:0];
        CFG_PROB_UP:     prob_r  <= cfg_wdata[30:0];
        CFG_STEP_DISC:   disc_r  <= cfg_wdata;
        CFG_NUM_STEPS:   steps_r <= cfg_wdata[8:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // clip the probability to one and the step count to the tree depth
  logic [30:0]     p_w, q_w;
  logic [VA_W-1:0] n_w;
  assign p_w = (prob_r > Q_ONE[30:0]) ? Q_ONE[30:0] : prob_r;
  assign q_w = Q_ONE[30:0] - p_w;
  assign n_w = (32'(steps_r) > 32'(MAX_STEPS)) ? VA_W'(MAX_STEPS) : VA_W'(steps_r);

  // hold the request for the whole tree walk
  logic [31:0] spot_r, strike_r;
  logic        put_r, amer_r;
  logic        accept;
  assign accept = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      spot_r   <= in_spot;
      strike_r <= in_strike;
      put_r    <= in_is_put;
      amer_r   <= in_american;
    end
  end

  issue_ctl_t      ctl;
  logic [SA_W-1:0] spot_rd, spot_wr;
  logic [VA_W-1:0] vaddr;
  logic            busy, idle, done, out_free;
  logic [31:0]     root_val;
  logic            sat;

  // result register parts the tree walk from the result channel
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] price_r;
  logic        osat_r;

  assign out_free = !out_valid_r || out_ready;

  bto_seq #(.MAX_STEPS(MAX_STEPS)) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .n_in     (n_w),
    .busy     (busy),
    .out_free (out_free),
    .idle     (idle),
    .done     (done),
    .ctl      (ctl),
    .spot_rd  (spot_rd),
    .spot_wr  (spot_wr),
    .vaddr    (vaddr)
  );

  bto_dp #(.MAX_STEPS(MAX_STEPS)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .spot_rd       (spot_rd),
    .spot_wr       (spot_wr),
    .vaddr         (vaddr),
    .seed_spot     (spot_r),
    .strike        (strike_r),
    .is_put        (put_r),
    .american      (amer_r),
    .up_factor     (up_r),
    .down_factor   (down_r),
    .p_w           (p_w),
    .q_w           (q_w),
    .step_discount (disc_r),
    .busy          (busy),
    .root_val      (root_val),
    .sat           (sat)
  );

  assign in_ready = idle;

  assign out_valid_nxt = done ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (done) begin
      price_r <= root_val;
      osat_r  <= sat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_price     = price_r;
  assign out_saturated = osat_r;

  // a result never lands on one still waiting
  `BTO_ASSERT(a_no_overwrite, !done || !out_valid_r || out_ready)
  // an idle sequencer leaves no node operation in flight
  `BTO_ASSERT(a_idle_empty, !in_ready || !busy)
  // a request holds the block until its walk is over
  `BTO_ASSERT_NEXT(a_accept_blocks, accept, !in_ready)

endmodule

// File: verif/bto_price_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binomial tree pricer checker
// Watches the request, result and register write ports, prices every accepted
// request with its own tree model and compares each result in order.
// ----------------------------------------------------------------------------
module bto_price_checker
  import bto_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_spot,
  input  logic [31:0] in_strike,
  input  logic        in_is_put,
  input  logic        in_american,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_price,
  input  logic        out_saturated,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  output int          fail_count,
  output int          pending_prices,
  output int          priced_count
);

  localparam int NMAX = MAX_STEPS_DEF;

  typedef struct packed {
    logic [31:0] price;
    logic        saturated;
  } price_t;

  logic [31:0] up_f, down_f, prob_f, disc_f;
  logic [8:0]  steps_f;
  price_t      expected_prices[$];

  logic [31:0] tree_val[NMAX+1];
  logic [31:0] dn_spot[NMAX+1];
  logic        dn_sat[NMAX+1];

  function automatic logic [31:0] fx_mul(logic [31:0] x, logic [31:0] f, ref logic sat);
    logic [63:0] r;
    r = ({32'd0, x} * {32'd0, f} + 64'h2000_0000) >> 30;
    if (r > 64'hFFFF_FFFF) begin
      sat = 1'b1;
      return 32'hFFFF_FFFF;
    end
    return r[31:0];
  endfunction

  function automatic logic [31:0] exercise(logic [31:0] s, logic [31:0] k, logic put);
    if (put) return (k > s) ? k - s : 32'd0;
    return (s > k) ? s - k : 32'd0;
  endfunction

  function automatic logic [31:0] spot_at(int lvl, int j, ref logic sat);
    logic [31:0] s;
    s = dn_spot[j];
    if (dn_sat[j]) sat = 1'b1;
    for (int i = j; i < lvl; i++) s = fx_mul(s, up_f, sat);
    return s;
  endfunction

  function automatic price_t price_tree(logic [31:0] spot, logic [31:0] k,
                                        logic put, logic amer);
    int          n;
    logic [63:0] p, q, mix, m, v;
    logic [31:0] val, ex;
    logic        sat, s;
    price_t      r;
    n = (steps_f > NMAX) ? NMAX : steps_f;
    p = (prob_f > 32'h4000_0000) ? 64'h4000_0000 : {32'd0, prob_f};
    q = 64'h4000_0000 - p;
    sat = 1'b0;
    dn_spot[0] = spot;
    dn_sat[0] = 1'b0;
    for (int j = 1; j <= n; j++) begin
      s = dn_sat[j-1];
      dn_spot[j] = fx_mul(dn_spot[j-1], down_f, s);
      dn_sat[j] = s;
    end
    for (int j = 0; j <= n; j++) tree_val[j] = exercise(spot_at(n, j, sat), k, put);
    for (int lvl = n - 1; lvl >= 0; lvl--) begin
      for (int j = 0; j <= lvl; j++) begin
        mix = p * tree_val[j] + q * tree_val[j+1];
        m = (mix + 64'h2000_0000) >> 30;
        v = (m * {32'd0, disc_f} + 64'h2000_0000) >> 30;
        if (v > 64'hFFFF_FFFF) begin
          sat = 1'b1;
          val = 32'hFFFF_FFFF;
        end else begin
          val = v[31:0];
        end
        if (amer) begin
          ex = exercise(spot_at(lvl, j, sat), k, put);
          if (ex > val) val = ex;
        end
        tree_val[j] = val;
      end
    end
    r.price = tree_val[0];
    r.saturated = sat;
    return r;
  endfunction

  always @(posedge clk) begin
    price_t exp_p;
    if (!rst_n) begin
      up_f <= Q_ONE;
      down_f <= Q_ONE;
      prob_f <= Q_HALF;
      disc_f <= Q_ONE;
      steps_f <= 9'd1;
      expected_prices.delete();
      fail_count <= 0;
      priced_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_UP_FACTOR:   up_f <= cfg_wdata;
          CFG_DOWN_FACTOR: down_f <= {1'b0, cfg_wdata[30:0]};
          CFG_PROB_UP:     prob_f <= {1'b0, cfg_wdata[30:0]};
          CFG_STEP_DISC:   disc_f <= cfg_wdata;
          CFG_NUM_STEPS:   steps_f <= cfg_wdata[8:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_prices.push_back(price_tree(in_spot, in_strike, in_is_put, in_american));
      if (out_valid && out_ready) begin
        priced_count <= priced_count + 1;
        if (expected_prices.size() == 0) begin
          if (fail_count < 10) $display("unexpected result price=%h", out_price);
          fail_count <= fail_count + 1;
        end else begin
          exp_p = expected_prices.pop_front();
          if (exp_p.price !== out_price || exp_p.saturated !== out_saturated) begin
            if (fail_count < 10)
              $display("mismatch: price exp %h got %h, sat exp %b got %b",
                       exp_p.price, out_price, exp_p.saturated, out_saturated);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  assign pending_prices = expected_prices.size();

endmodule

// File: verif/tb_binomial_tree_option_pricer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binomial tree pricer testbench
// Drives option requests over several tree settings with random idling and a
// long result hold-off; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_binomial_tree_option_pricer;
  import bto_pkg::*;

  logic        clk, rst_n;
  logic        in_valid, in_ready;
  logic [31:0] in_spot, in_strike;
  logic        in_is_put, in_american;
  logic        out_valid, out_ready;
  logic [31:0] out_price;
  logic        out_saturated;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [31:0] cfg_wdata;
  int          fail_count, pending_prices, priced_count;
  int          sent_count;
  bit          calm;      // no idling on either side while set
  bit          hold_off;  // receiver stalls for a long stretch

  binomial_tree_option_pricer u_dut (.*);
  bto_price_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Safety net: far beyond the slowest legitimate run.
  initial begin
    #200ms;
    $display("FAIL binomial_tree_option_pricer");
    $finish;
  end

  // Receiver: random stalls, none while calm, solid stall during hold-off.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) out_ready <= 1'b0;
      else out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 10);
    end
  end

  // Long hold-off counted in cycles, started once forty requests have been sent.
  initial begin
    hold_off = 1'b0;
    wait (sent_count == 40);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (3000) @(negedge clk);
    hold_off = 1'b0;
  end

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_tree(logic [31:0] u, logic [31:0] d, logic [31:0] p,
                           logic [31:0] disc, logic [8:0] n);
    write_reg(CFG_UP_FACTOR, u);
    write_reg(CFG_DOWN_FACTOR, d);
    write_reg(CFG_PROB_UP, p);
    write_reg(CFG_STEP_DISC, disc);
    write_reg(CFG_NUM_STEPS, {23'd0, n});
  endtask

  // Offer one request, holding it until accepted, with random gaps before.
  task automatic send_request(logic [31:0] s, logic [31:0] k, logic put, logic amer);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 10) @(negedge clk);
    in_valid <= 1'b1;
    in_spot <= s;
    in_strike <= k;
    in_is_put <= put;
    in_american <= amer;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Wait until every result is in, then let the block settle.
  task automatic drain();
    int guard;
    guard = 0;
    while (pending_prices != 0 && guard < 4000000) begin
      @(negedge clk);
      guard++;
    end
    repeat (200) @(negedge clk);
  endtask

  task automatic random_phase(int count);
    logic [31:0] s, k;
    for (int i = 0; i < count; i++) begin
      s = $urandom();
      case ($urandom_range(3))
        0: k = $urandom();
        1: k = s ^ ($urandom() & 32'h0003_FFFF);
        2: k = {8'd0, 8'($urandom_range(255)), 16'h0} | ($urandom() & 32'h0000_FFFF);
        default: k = s;
      endcase
      if ($urandom_range(3) == 0) s = s >> $urandom_range(24);
      send_request(s, k, 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_spot = '0;
    in_strike = '0;
    in_is_put = 1'b0;
    in_american = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    calm = 1'b0;
    sent_count = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset defaults, one step.
    send_request(32'd0, 32'd0, 1'b0, 1'b0);
    send_request(32'hFFFF_FFFF, 32'd0, 1'b0, 1'b0);
    send_request(32'd0, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send_request(32'h0064_0000, 32'h0064_0000, 1'b1, 1'b0);
    drain();

    // Zero steps: the root is a leaf.
    load_tree(32'h4666_6666, 32'h39D8_9D8A, 32'h2000_0000, 32'h3FF0_0000, 9'd0);
    send_request(32'h0064_0000, 32'h005A_0000, 1'b0, 1'b0);
    send_request(32'h0064_0000, 32'h006E_0000, 1'b1, 1'b1);
    drain();

    // Typical tree, all four kinds.
    write_reg(CFG_NUM_STEPS, 32'd8);
    send_request(32'h0064_0000, 32'h0064_0000, 1'b0, 1'b0);
    send_request(32'h0064_0000, 32'h0064_0000, 1'b0, 1'b1);
    send_request(32'h0064_0000, 32'h0064_0000, 1'b1, 1'b0);
    send_request(32'h0064_0000, 32'h0078_0000, 1'b1, 1'b1);
    drain();

    // Probability above one, huge up factor and discount: saturation.
    load_tree(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 9'd6);
    send_request(32'hFFFF_FFFF, 32'd0, 1'b0, 1'b1);
    send_request(32'h0001_0000, 32'd0, 1'b0, 1'b0);
    send_request(32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1);
    drain();

    // Zero down factor, probability and discount.
    load_tree(32'h4000_0000, 32'd0, 32'd0, 32'd0, 9'd3);
    send_request(32'h0064_0000, 32'h0032_0000, 1'b1, 1'b1);
    send_request(32'h0064_0000, 32'h0032_0000, 1'b0, 1'b0);
    drain();

    // Largest depth once, and a step count past the maximum.
    load_tree(32'h4040_0000, 32'h3FC0_0000, 32'h2100_0000, 32'h3FFF_0000, 9'd256);
    send_request(32'h0064_0000, 32'h0064_0000, 1'b1, 1'b1);
    drain();
    write_reg(CFG_NUM_STEPS, 32'd511);
    send_request(32'h0064_0000, 32'h0060_0000, 1'b0, 1'b0);
    drain();

    // Random phases, mostly small trees; includes the long hold-off.
    load_tree(32'h4333_3333, 32'h3CF3_CF3D, 32'h2300_0000, 32'h3FF8_0000, 9'd5);
    random_phase(30);
    drain();
    calm = 1'b1;
    load_tree($urandom(), $urandom() & 32'h4000_0000, $urandom(), $urandom(), 9'd4);
    random_phase(20);
    drain();
    calm = 1'b0;
    for (int ph = 0; ph < 5; ph++) begin
      load_tree(32'h4000_0000 + ($urandom() & 32'h0FFF_FFFF),
                32'h3000_0000 + ($urandom() & 32'h0FFF_FFFF),
                $urandom() & 32'h7FFF_FFFF, $urandom(), 9'($urandom_range(12, 1)));
      random_phase(10);
      drain();
    end

    $display("Priced %0d requests over fourteen tree settings: zero, one, deep and",
             priced_count);
    $display("over-range steps, saturating factors, both kinds and exercise styles.");
    if (fail_count == 0 && pending_prices == 0) begin
      $display("PASS binomial_tree_option_pricer");
    end else begin
      $display("FAIL binomial_tree_option_pricer");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/bto_pkg.sv
rtl/bto_seq.sv
rtl/bto_dp.sv
rtl/binomial_tree_option_pricer.sv
verif/bto_price_checker.sv
verif/tb_binomial_tree_option_pricer.sv
